>>> rtl/sorted_timer_queue_core_defines.svh
`ifndef SORTED_TIMER_QUEUE_CORE_DEFINES_SVH
`define SORTED_TIMER_QUEUE_CORE_DEFINES_SVH

// same-cycle implication on the checker clock, off during reset
`define STQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on the checker clock, off during reset
`define STQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/stq_pkg.sv
`timescale 1ns / 1ps

package stq_pkg;

   localparam int TIME_W = 48;
   localparam int ID_W   = 8;
   localparam int WAIT_W = 49;
   localparam int FUNC_W = 2;

   localparam int unsigned FRAC_BITS    = 16;
   localparam int unsigned IDLE_SECONDS = 3600;
   localparam logic [TIME_W-1:0] IDLE_WAIT_RESET = TIME_W'(IDLE_SECONDS) << FRAC_BITS;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_START = 2'd0,
      FUNC_STOP  = 2'd1,
      FUNC_CHECK = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_REMOVE = 2'd1,
      CELL_INSERT = 2'd2,
      CELL_POP    = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] deadline;
   } cell_cmd_type;

endpackage

>>> rtl/stq_cell.sv
`timescale 1ns / 1ps

module stq_cell (
   input  logic                        clock,
   input  stq_pkg::cell_cmd_type       cmd,
   input  logic                        occupied,
   input  logic                        left_less,
   input  logic [stq_pkg::ID_W-1:0]    left_id,
   input  logic [stq_pkg::TIME_W-1:0]  left_deadline,
   input  logic [stq_pkg::ID_W-1:0]    right_id,
   input  logic [stq_pkg::TIME_W-1:0]  right_deadline,
   input  logic                        hit_in,
   output logic                        less,
   output logic                        hit_out,
   output logic [stq_pkg::ID_W-1:0]    id,
   output logic [stq_pkg::TIME_W-1:0]  deadline
);

   logic [stq_pkg::ID_W-1:0]   id_ff, id_in;
   logic [stq_pkg::TIME_W-1:0] deadline_ff, deadline_in;
   logic                       match;

   assign less     = occupied && (deadline_ff < cmd.deadline);
   assign match    = occupied && (id_ff == cmd.id);
   assign hit_out  = hit_in | match;
   assign id       = id_ff;
   assign deadline = deadline_ff;

   always_comb begin
      id_in       = id_ff;
      deadline_in = deadline_ff;
      case (cmd.op)
         stq_pkg::CELL_REMOVE: begin
            // close the gap left by the matching entry
            if (hit_out) begin
               id_in       = right_id;
               deadline_in = right_deadline;
            end
         end
         stq_pkg::CELL_INSERT: begin
            if (!less) begin
               if (left_less) begin
                  id_in       = cmd.id;
                  deadline_in = cmd.deadline;
               end else begin
                  id_in       = left_id;
                  deadline_in = left_deadline;
               end
            end
         end
         stq_pkg::CELL_POP: begin
            id_in       = right_id;
            deadline_in = right_deadline;
         end
         default: begin
            id_in       = id_ff;
            deadline_in = deadline_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      deadline_ff <= deadline_in;
   end

endmodule

>>> rtl/sorted_timer_queue_core.sv
// steps: start goes capture, remove, insert, result; stop goes capture, remove, result;
//    unused func goes capture, result; check goes capture, one pop per expiry, result
// one item at a time; the next can be taken in the same cycle its final result shows
// the cell chain does one shift step per cycle, holding while a result is stalled
// reset (synchronous, active high) empties the queue and sets idle_wait to 3600 s
`timescale 1ns / 1ps

module sorted_timer_queue_core #(
   parameter int TIMERS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [stq_pkg::TIME_W-1:0]         csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [stq_pkg::FUNC_W-1:0]         req_func,
   input  logic [stq_pkg::ID_W-1:0]           req_timer_id,
   input  logic [stq_pkg::TIME_W-1:0]         req_deadline,
   input  logic [stq_pkg::TIME_W-1:0]         req_now_time,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_expired_valid,
   output logic [stq_pkg::ID_W-1:0]           rsp_expired_id,
   output logic signed [stq_pkg::WAIT_W-1:0]  rsp_wait_time,
   output logic                               rsp_overflow,
   output logic                               rsp_last
);

   localparam int CNT_W = $clog2(TIMERS + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TIMERS);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_REMOVE = 5'b00010,
      S_INSERT = 5'b00100,
      S_CHECK  = 5'b01000,
      S_FINAL  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [stq_pkg::TIME_W-1:0] idle_wait_ff, idle_wait_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       ovf_ff, ovf_in;

   stq_pkg::func_type          func_ff, func_in;
   logic [stq_pkg::ID_W-1:0]   id_ff, id_in;
   logic [stq_pkg::TIME_W-1:0] deadline_ff, deadline_in;
   logic [stq_pkg::TIME_W-1:0] now_ff, now_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_expired_valid_ff, rsp_expired_valid_in;
   logic [stq_pkg::ID_W-1:0]          rsp_expired_id_ff, rsp_expired_id_in;
   logic signed [stq_pkg::WAIT_W-1:0] rsp_wait_time_ff, rsp_wait_time_in;
   logic                              rsp_overflow_ff, rsp_overflow_in;
   logic                              rsp_last_ff, rsp_last_in;

   stq_pkg::cell_cmd_type      cmd;
   logic [TIMERS-1:0]          occupied;
   logic [TIMERS-1:0]          less_w;
   logic [TIMERS:0]            hit_w;
   logic [stq_pkg::ID_W-1:0]   id_w [TIMERS];
   logic [stq_pkg::TIME_W-1:0] deadline_w [TIMERS];

   logic accept;
   logic out_free;
   logic head_expired;
   logic [stq_pkg::WAIT_W-1:0] head_wait;

   assign req_stall    = (state_ff != S_IDLE);
   assign accept       = req_valid && !req_stall;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign head_expired = (count_ff != '0) && (deadline_w[0] < now_ff);
   assign head_wait    = {1'b0, deadline_w[0]} - {1'b0, now_ff};

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_expired_valid = rsp_expired_valid_ff;
   assign rsp_expired_id    = rsp_expired_id_ff;
   assign rsp_wait_time     = rsp_wait_time_ff;
   assign rsp_overflow      = rsp_overflow_ff;
   assign rsp_last          = rsp_last_ff;

   assign hit_w[0] = 1'b0;

   genvar gi;
   generate
      for (gi = 0; gi < TIMERS; gi++) begin : g_cell
         logic                       l_less;
         logic [stq_pkg::ID_W-1:0]   l_id, r_id;
         logic [stq_pkg::TIME_W-1:0] l_deadline, r_deadline;

         assign occupied[gi] = (CNT_W'(gi) < count_ff);

         if (gi == 0) begin : g_head
            // a new entry lands at the front when nothing is earlier
            assign l_less     = 1'b1;
            assign l_id       = '0;
            assign l_deadline = '0;
         end else begin : g_body
            assign l_less     = less_w[gi-1];
            assign l_id       = id_w[gi-1];
            assign l_deadline = deadline_w[gi-1];
         end

         if (gi == TIMERS - 1) begin : g_tail
            assign r_id       = '0;
            assign r_deadline = '0;
         end else begin : g_inner
            assign r_id       = id_w[gi+1];
            assign r_deadline = deadline_w[gi+1];
         end

         stq_cell u_cell (
            .clock          (clock),
            .cmd            (cmd),
            .occupied       (occupied[gi]),
            .left_less      (l_less),
            .left_id        (l_id),
            .left_deadline  (l_deadline),
            .right_id       (r_id),
            .right_deadline (r_deadline),
            .hit_in         (hit_w[gi]),
            .less           (less_w[gi]),
            .hit_out        (hit_w[gi+1]),
            .id             (id_w[gi]),
            .deadline       (deadline_w[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      idle_wait_in = idle_wait_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      func_in      = func_ff;
      id_in        = id_ff;
      deadline_in  = deadline_ff;
      now_in       = now_ff;

      cmd.op       = stq_pkg::CELL_HOLD;
      cmd.id       = id_ff;
      cmd.deadline = deadline_ff;

      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_expired_valid_in = rsp_expired_valid_ff;
      rsp_expired_id_in    = rsp_expired_id_ff;
      rsp_wait_time_in     = rsp_wait_time_ff;
      rsp_overflow_in      = rsp_overflow_ff;
      rsp_last_in          = rsp_last_ff;

      if (csr_wr_en) begin
         idle_wait_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in     = stq_pkg::func_type'(req_func);
               id_in       = req_timer_id;
               deadline_in = req_deadline;
               now_in      = req_now_time;
               ovf_in      = 1'b0;
               case (req_func)
                  stq_pkg::FUNC_START: state_in = S_REMOVE;
                  stq_pkg::FUNC_STOP:  state_in = S_REMOVE;
                  stq_pkg::FUNC_CHECK: state_in = S_CHECK;
                  default:             state_in = S_FINAL;
               endcase
            end
         end
         S_REMOVE: begin
            cmd.op = stq_pkg::CELL_REMOVE;
            if (hit_w[TIMERS]) begin
               count_in = count_ff - 1'b1;
            end
            state_in = (func_ff == stq_pkg::FUNC_START) ? S_INSERT : S_FINAL;
         end
         S_INSERT: begin
            if (count_ff == CNT_FULL) begin
               ovf_in = 1'b1;
            end else begin
               cmd.op   = stq_pkg::CELL_INSERT;
               count_in = count_ff + 1'b1;
            end
            state_in = S_FINAL;
         end
         S_CHECK: begin
            if (!head_expired) begin
               state_in = S_FINAL;
            end else if (out_free) begin
               cmd.op               = stq_pkg::CELL_POP;
               count_in             = count_ff - 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_expired_valid_in = 1'b1;
               rsp_expired_id_in    = id_w[0];
               rsp_wait_time_in     = '0;
               rsp_overflow_in      = 1'b0;
               rsp_last_in          = 1'b0;
            end
         end
         S_FINAL: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_expired_valid_in = 1'b0;
               rsp_expired_id_in    = '0;
               rsp_wait_time_in     = (count_ff == '0) ? $signed({1'b0, idle_wait_ff})
                                                       : $signed(head_wait);
               rsp_overflow_in      = ovf_ff;
               rsp_last_in          = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idle_wait_ff <= stq_pkg::IDLE_WAIT_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idle_wait_ff <= idle_wait_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff               <= ovf_in;
      func_ff              <= func_in;
      id_ff                <= id_in;
      deadline_ff          <= deadline_in;
      now_ff               <= now_in;
      rsp_expired_valid_ff <= rsp_expired_valid_in;
      rsp_expired_id_ff    <= rsp_expired_id_in;
      rsp_wait_time_ff     <= rsp_wait_time_in;
      rsp_overflow_ff      <= rsp_overflow_in;
      rsp_last_ff          <= rsp_last_in;
   end

endmodule

>>> rtl/stq_checker.sv
`timescale 1ns / 1ps
`include "sorted_timer_queue_core_defines.svh"

module stq_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_expired_valid,
   input logic [stq_pkg::ID_W-1:0]           rsp_expired_id,
   input logic signed [stq_pkg::WAIT_W-1:0]  rsp_wait_time,
   input logic                               rsp_overflow,
   input logic                               rsp_last
);

   // an expired transaction carries no wait, no overflow and is never the last
   `STQ_ASSERT_NOW(a_expired_shape, rsp_valid && rsp_expired_valid, !rsp_last && !rsp_overflow && (rsp_wait_time == '0), "expired transaction has stray fields")

   // the final transaction never reports an expiry
   `STQ_ASSERT_NOW(a_final_shape, rsp_valid && rsp_last, !rsp_expired_valid && (rsp_expired_id == '0), "final transaction reports an expiry")

   // every transaction is either an expiry or the final one
   `STQ_ASSERT_NOW(a_kind, rsp_valid, rsp_expired_valid || rsp_last, "transaction is neither expiry nor final")

   // one item at a time: the cycle after an accepted item the input is held off
   `STQ_ASSERT_NEXT(a_busy, req_valid && !req_stall, req_stall, "input not held off while an item is in work")

endmodule

bind sorted_timer_queue_core stq_checker u_stq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_expired_valid (rsp_expired_valid),
   .rsp_expired_id    (rsp_expired_id),
   .rsp_wait_time     (rsp_wait_time),
   .rsp_overflow      (rsp_overflow),
   .rsp_last          (rsp_last)
);

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

   typedef logic [stq_pkg::FUNC_W-1:0] func_code_type;
   typedef logic [stq_pkg::ID_W-1:0]   id_type;
   typedef logic [stq_pkg::TIME_W-1:0] time_type;
   typedef logic [stq_pkg::WAIT_W-1:0] wait_type;

   localparam int TIMERS         = 16;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam func_code_type FUNC_UNUSED = 2'd3;
   localparam time_type      TIME_MAX    = '1;

   typedef struct packed {
      logic     expired_valid;
      id_type   expired_id;
      wait_type wait_time;
      logic     overflow;
      logic     last;
   } timer_rsp_type;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       csr_wr_en   = 1'b0;
   time_type                   csr_wr_data = '0;
   logic                       req_valid   = 1'b0;
   logic                       req_stall;
   func_code_type              req_func     = '0;
   id_type                     req_timer_id = '0;
   time_type                   req_deadline = '0;
   time_type                   req_now_time = '0;
   logic                       rsp_valid;
   logic                       rsp_stall   = 1'b0;
   logic                       rsp_expired_valid;
   id_type                     rsp_expired_id;
   logic signed [stq_pkg::WAIT_W-1:0] rsp_wait_time;
   logic                       rsp_overflow;
   logic                       rsp_last;

   // timer list as the block should hold it, front first
   time_type list_deadline [TIMERS];
   id_type   list_id [TIMERS];
   int       list_count;
   time_type idle_wait_now;

   timer_rsp_type timer_results_ahead[$];

   int  n_errors    = 0;
   int  n_items     = 0;
   int  n_results   = 0;
   int  n_expired   = 0;
   int  n_overflow  = 0;
   int  hold_request = 0;
   bit  tx_idle     = 1'b1;
   bit  rx_idle     = 1'b1;
   time_type timeline;

   sorted_timer_queue_core #(.TIMERS(TIMERS)) DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_timer_id      (req_timer_id),
      .req_deadline      (req_deadline),
      .req_now_time      (req_now_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_expired_valid (rsp_expired_valid),
      .rsp_expired_id    (rsp_expired_id),
      .rsp_wait_time     (rsp_wait_time),
      .rsp_overflow      (rsp_overflow),
      .rsp_last          (rsp_last)
   );

   always #5 clock = ~clock;

   function automatic time_type rand_time();
      return time_type'({$urandom, $urandom});
   endfunction

   function automatic int find_timer(id_type id);
      for (int i = 0; i < list_count; i++)
         if (list_id[i] == id) return i;
      return -1;
   endfunction

   function automatic void drop_timer(int pos);
      for (int i = pos; i + 1 < list_count; i++) begin
         list_deadline[i] = list_deadline[i + 1];
         list_id[i]       = list_id[i + 1];
      end
      list_count--;
   endfunction

   // updates the timer list for one transaction and queues the results it owes
   function automatic void apply_timer_item(func_code_type func, id_type id,
                                            time_type deadline, time_type now_time);
      timer_rsp_type r;
      int            pos;
      logic          ovf;
      ovf = 1'b0;
      case (func)
         stq_pkg::FUNC_START: begin
            pos = find_timer(id);
            if (pos >= 0) drop_timer(pos);
            if (list_count >= TIMERS) begin
               ovf = 1'b1;
            end else begin
               pos = 0;
               while (pos < list_count && list_deadline[pos] < deadline) pos++;
               for (int i = list_count; i > pos; i--) begin
                  list_deadline[i] = list_deadline[i - 1];
                  list_id[i]       = list_id[i - 1];
               end
               list_deadline[pos] = deadline;
               list_id[pos]       = id;
               list_count++;
            end
         end
         stq_pkg::FUNC_STOP: begin
            pos = find_timer(id);
            if (pos >= 0) drop_timer(pos);
         end
         stq_pkg::FUNC_CHECK: begin
            // strictly earlier deadlines expire, front first
            while (list_count > 0 && list_deadline[0] < now_time) begin
               r = '{expired_valid: 1'b1, expired_id: list_id[0], wait_time: '0,
                     overflow: 1'b0, last: 1'b0};
               timer_results_ahead.push_back(r);
               drop_timer(0);
            end
         end
         default: ;
      endcase
      r = '{expired_valid: 1'b0, expired_id: '0, wait_time: '0, overflow: ovf, last: 1'b1};
      if (list_count == 0)
         r.wait_time = {1'b0, idle_wait_now};
      else
         r.wait_time = {1'b0, list_deadline[0]} - {1'b0, now_time};
      timer_results_ahead.push_back(r);
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
      n_errors++;
   endtask

   // sender: optional gap, then hold the transaction until it is taken
   task automatic send_item(func_code_type func, id_type id,
                            time_type deadline, time_type now_time);
      int gap;
      gap = tx_idle ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= func;
      req_timer_id <= id;
      req_deadline <= deadline;
      req_now_time <= now_time;
      do @(posedge clock); while (req_stall);
      apply_timer_item(func, id, deadline, now_time);
      n_items++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (timer_results_ahead.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_idle_wait(time_type value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      idle_wait_now = value;
   endtask

   // receiver: random stall after each taken result, or a long hold when asked
   always @(posedge clock) begin : rsp_side
      int stall_left;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end else if (rsp_valid && !rsp_stall) begin
            stall_left = rx_idle ? $urandom_range(0, 13) : 0;
         end
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   always @(posedge clock) begin : rsp_check
      timer_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (rsp_expired_valid) n_expired++;
         if (rsp_overflow) n_overflow++;
         if (timer_results_ahead.size() == 0) begin
            report_mismatch("unexpected transaction", 64'(rsp_last), '0);
         end else begin
            want = timer_results_ahead.pop_front();
            if (rsp_expired_valid !== want.expired_valid)
               report_mismatch("expired_valid", 64'(rsp_expired_valid),
                               64'(want.expired_valid));
            if (rsp_expired_id !== want.expired_id)
               report_mismatch("expired_id", 64'(rsp_expired_id), 64'(want.expired_id));
            if (rsp_wait_time !== want.wait_time)
               report_mismatch("wait_time", 64'($unsigned(rsp_wait_time)),
                               64'(want.wait_time));
            if (rsp_overflow !== want.overflow)
               report_mismatch("overflow", 64'(rsp_overflow), 64'(want.overflow));
            if (rsp_last !== want.last)
               report_mismatch("last", 64'(rsp_last), 64'(want.last));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet;
      if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet = 0;
      else
         quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $realtime, quiet);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic test_directed_list();
      int k;
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      // empty list reports the reset idle wait
      send_item(stq_pkg::FUNC_CHECK, 8'd0, '0, '0);
      send_item(FUNC_UNUSED, 8'd255, TIME_MAX, TIME_MAX);
      // fill in scrambled deadline order, equal pairs go newest first
      for (int i = 0; i < TIMERS; i++) begin
         k = (i * 7) % TIMERS;
         send_item(stq_pkg::FUNC_START, id_type'(i * 17),
                   (k == 0) ? '0 : (k == TIMERS - 1) ? TIME_MAX
                                 : time_type'(k / 2) << stq_pkg::FRAC_BITS,
                   (i % 4 == 3) ? 48'h8000_0000_0000 : '0);
      end
      send_item(stq_pkg::FUNC_START, 8'd1, 48'd100, 48'd0);       // full, new id dropped
      send_item(stq_pkg::FUNC_START, 8'd51, time_type'(5) << stq_pkg::FRAC_BITS,
                48'd0);                                           // restart fits when full
      send_item(stq_pkg::FUNC_STOP, 8'd85, '0, 48'd7);
      send_item(stq_pkg::FUNC_STOP, 8'd1, '0, 48'd7);             // unknown id
      send_item(stq_pkg::FUNC_CHECK, 8'd0, '0, 48'd0);            // deadline zero not yet due
      send_item(stq_pkg::FUNC_CHECK, 8'd0, '0, 48'd1);
      send_item(stq_pkg::FUNC_CHECK, 8'd0, '0, TIME_MAX);
      send_item(stq_pkg::FUNC_STOP, 8'd153, '0, TIME_MAX);
      drain_results();
   endtask

   task automatic test_idle_wait_register();
      write_idle_wait('0);
      send_item(stq_pkg::FUNC_CHECK, id_type'($urandom), rand_time(), rand_time());
      drain_results();
      write_idle_wait(TIME_MAX);
      send_item(stq_pkg::FUNC_STOP, id_type'($urandom), rand_time(), rand_time());
      drain_results();
      write_idle_wait(rand_time());
      send_item(FUNC_UNUSED, id_type'($urandom), rand_time(), rand_time());
      drain_results();
   endtask

   task automatic test_random_traffic(time_type idle_value, bit tx_gaps,
                                      bit rx_gaps, int count);
      func_code_type func;
      id_type        id;
      time_type      deadline;
      time_type      now_time;
      int            pick;
      write_idle_wait(idle_value);
      tx_idle  = tx_gaps;
      rx_idle  = rx_gaps;
      timeline = rand_time();
      repeat (count) begin
         pick     = $urandom_range(0, 99);
         deadline = rand_time();
         if (pick < 15) begin
            func     = func_code_type'($urandom_range(0, 3));
            id       = id_type'($urandom);
            now_time = rand_time();
         end else begin
            // small id pool keeps restarts, stops and a full list common
            id = ($urandom_range(0, 9) == 0) ? id_type'($urandom)
                                              : id_type'($urandom_range(0, 19));
            timeline = timeline + ($urandom_range(0, 3) << 14);
            now_time = timeline;
            if (pick < 60) begin
               func     = stq_pkg::FUNC_START;
               deadline = timeline + ($urandom_range(0, 15) << 14) - (1 << 15);
            end else if (pick < 75) begin
               func = stq_pkg::FUNC_STOP;
            end else begin
               func = stq_pkg::FUNC_CHECK;
            end
         end
         send_item(func, id, deadline, now_time);
      end
      drain_results();
   endtask

   // receiver holds off while the sender keeps offering back to back
   task automatic test_back_pressure();
      @(negedge clock);
      hold_request = HOLD_CYCLES;
      @(posedge clock);
      tx_idle = 1'b0;
      rx_idle = 1'b1;
      for (int i = 0; i < 12; i++)
         send_item((i % 3 == 2) ? stq_pkg::FUNC_CHECK : stq_pkg::FUNC_START,
                   id_type'($urandom_range(0, 19)),
                   timeline + ($urandom_range(0, 15) << 14), timeline + (i << 15));
      drain_results();
   endtask

   initial begin
      list_count    = 0;
      idle_wait_now = stq_pkg::IDLE_WAIT_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_list();
      test_idle_wait_register();
      test_random_traffic(rand_time(), 1'b1, 1'b1, 72);
      test_random_traffic('0, 1'b0, 1'b0, 72);
      test_random_traffic(TIME_MAX, 1'b1, 1'b0, 72);
      test_random_traffic(stq_pkg::IDLE_WAIT_RESET, 1'b0, 1'b1, 72);
      test_back_pressure();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("run covered %0d timer transactions in and %0d results out", n_items, n_results);
      $display("results held %0d expirations and %0d dropped starts, %0d mismatches",
               n_expired, n_overflow, n_errors);
      if (n_errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
